### hw/rtl/pfd_pkg.sv
// Shared types and constants of the PPM frame decoder.
// Holds the configuration record, the command word between front and back,
// and the result word. No dependencies.
package pfd_pkg;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_SYNC_PAUSE_MIN    = 3'd0,
		REG_PULSE_MIN         = 3'd1,
		REG_PULSE_MAX         = 3'd2,
		REG_CHANNEL_COUNT     = 3'd3,
		REG_BAD_FRAME_PENALTY = 3'd4,
		REG_BUCKET_LIMIT      = 3'd5,
		REG_SIGNAL_TIMEOUT_MS = 3'd6,
		REG_HALVING_MODE      = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	localparam logic [14:0] RST_SYNC_PAUSE_MIN    = 15'd6250;
	localparam logic [14:0] RST_PULSE_MIN         = 15'd1250;
	localparam logic [14:0] RST_PULSE_MAX         = 15'd2500;
	localparam logic [3:0]  RST_CHANNEL_COUNT     = 4'd8;
	localparam logic [6:0]  RST_BAD_FRAME_PENALTY = 7'd4;
	localparam logic [6:0]  RST_BUCKET_LIMIT      = 7'd20;
	localparam logic [15:0] RST_SIGNAL_TIMEOUT_MS = 16'd500;
	localparam logic        RST_HALVING_MODE      = 1'b0;

	typedef struct packed {
		logic [14:0] sync_pause_min;
		logic [14:0] pulse_min;
		logic [14:0] pulse_max;
		logic [3:0]  channel_count;
		logic [6:0]  bad_frame_penalty;
		logic [6:0]  bucket_limit;
		logic [15:0] signal_timeout_ms;
		logic        halving_mode;
	} cfg_t;

	// Classified word handed from the front to the back.
	typedef struct packed {
		logic        tick;
		logic        sync;
		logic        take;
		logic        ok;
		logic        frame_end;
		logic [3:0]  idx;
		logic [14:0] nv;
		logic [14:0] sync_w;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [14:0] value;
		logic        stored;
		logic        glitch;
		logic        sync;
		logic        frame_end;
		logic        new_values;
		logic        signal;
		logic [15:0] glitch_count;
		logic [14:0] pause_width;
		logic [23:0] ms_time;
	} res_t;

endpackage

### hw/rtl/pfd_fifo.sv
// Small first-in first-out queue of flat words.
// Used between front and back and in front of the result ports. No dependencies.
module pfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/pfd_front.sv
// Front end: measures the edge interval and classifies each word.
// Keeps the previous edge time and the channel index. Depends on pfd_pkg.
module pfd_front #(
	parameter int MAX_CHANNELS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          opcode,
	input  logic [15:0]   edge_time,
	input  pfd_pkg::cfg_t cfg,
	output pfd_pkg::cmd_t cmd
);
	import pfd_pkg::*;

	logic [15:0] prev_edge_q;
	logic [3:0]  ch_idx_q;
	logic [15:0] width;
	logic [15:0] half;
	logic [4:0]  eff_count;
	logic        is_edge;
	logic        is_sync;
	logic        take;
	logic        ok;
	logic [14:0] nv;

	always_comb begin
		is_edge = (opcode_t'(opcode) == OP_EDGE);
		width   = edge_time - prev_edge_q;
		half    = {width[15], width[15:1]};
		if ({1'b0, cfg.channel_count} > 5'(MAX_CHANNELS)) begin
			eff_count = 5'(MAX_CHANNELS);
		end else begin
			eff_count = {1'b0, cfg.channel_count};
		end
		// A negative interval is never a sync and fails both pulse tests.
		is_sync = is_edge && !width[15] && (width[14:0] > cfg.sync_pause_min);
		take    = is_edge && !is_sync && ({1'b0, ch_idx_q} < eff_count);
		if (cfg.halving_mode) begin
			ok = (half[15:8] == 8'd1);
			nv = half[14:0];
		end else begin
			ok = !width[15] && (width[14:0] >= cfg.pulse_min)
				&& (width[14:0] <= cfg.pulse_max);
			nv = width[14:0] - cfg.pulse_min;
		end
		cmd.tick      = !is_edge;
		cmd.sync      = is_sync;
		cmd.take      = take;
		cmd.ok        = ok;
		cmd.frame_end = take && (({1'b0, ch_idx_q} + 5'd1) == eff_count);
		cmd.idx       = ch_idx_q;
		cmd.nv        = nv;
		cmd.sync_w    = width[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_edge_q <= '0;
			ch_idx_q    <= '0;
		end else if (accept && is_edge) begin
			prev_edge_q <= edge_time;
			if (is_sync) begin
				ch_idx_q <= '0;
			end else if (take) begin
				ch_idx_q <= ch_idx_q + 4'd1;
			end
		end
	end

endmodule

### hw/rtl/pfd_back.sv
// Back end: applies classified words to the channel values, glitch count,
// quality counter, signal flag and millisecond clock. Depends on pfd_pkg.
module pfd_back #(
	parameter int MAX_CHANNELS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  pfd_pkg::cmd_t cmd,
	input  pfd_pkg::cfg_t cfg,
	output pfd_pkg::res_t res
);
	import pfd_pkg::*;

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [14:0]       vals_q [MAX_CHANNELS];
	logic              frame_good_q;
	logic              new_values_q;
	logic signed [7:0] quality_q;
	logic              signal_q;
	logic [15:0]       rejected_q;
	logic [14:0]       sync_width_q;
	logic [23:0]       ms_q;
	logic [23:0]       deadline_q;

	logic [IDX_W-1:0]  idx;
	logic              fg_eff;
	logic signed [8:0] q_sum;
	logic signed [8:0] lim;
	logic signed [8:0] q_clamp;
	logic [23:0]       ms_inc;
	logic [23:0]       diff;
	logic              timed_out;

	always_comb begin
		idx    = cmd.idx[IDX_W-1:0];
		fg_eff = frame_good_q && cmd.ok;
		lim    = $signed({2'b00, cfg.bucket_limit});
		if (fg_eff) begin
			q_sum = 9'(quality_q) + 9'sd1;
		end else begin
			q_sum = 9'(quality_q) - $signed({2'b00, cfg.bad_frame_penalty});
		end
		if (q_sum > lim) begin
			q_clamp = lim;
		end else if (q_sum < -lim) begin
			q_clamp = -lim;
		end else begin
			q_clamp = q_sum;
		end
		ms_inc    = ms_q + 24'd1;
		diff      = ms_inc - deadline_q;
		timed_out = signal_q && (diff != '0) && !diff[23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				vals_q[i] <= '0;
			end
			frame_good_q <= 1'b0;
			new_values_q <= 1'b0;
			quality_q    <= '0;
			signal_q     <= 1'b0;
			rejected_q   <= '0;
			sync_width_q <= '0;
			ms_q         <= '0;
			deadline_q   <= '0;
		end else if (fire) begin
			if (cmd.tick) begin
				ms_q <= ms_inc;
				if (timed_out) begin
					signal_q  <= 1'b0;
					quality_q <= 8'(-lim);
				end
			end else if (cmd.sync) begin
				frame_good_q <= 1'b1;
				new_values_q <= 1'b0;
				sync_width_q <= cmd.sync_w;
			end else if (cmd.take) begin
				if (cmd.ok) begin
					vals_q[idx] <= cmd.nv;
				end else begin
					rejected_q   <= rejected_q + 16'd1;
					frame_good_q <= 1'b0;
				end
				if (cmd.frame_end) begin
					new_values_q <= fg_eff;
					quality_q    <= 8'(q_clamp);
					signal_q     <= (q_clamp > 9'sd0);
					deadline_q   <= ms_q + {8'd0, cfg.signal_timeout_ms};
				end
			end
		end
	end

	// The result shows the state as it stands after this word.
	always_comb begin
		res.channel      = cmd.take ? cmd.idx : 4'd0;
		res.value        = cmd.take ? (cmd.ok ? cmd.nv : vals_q[idx]) : 15'd0;
		res.stored       = cmd.take && cmd.ok;
		res.glitch       = cmd.take && !cmd.ok;
		res.sync         = cmd.sync;
		res.frame_end    = cmd.frame_end;
		res.new_values   = cmd.sync ? 1'b0
			: (cmd.frame_end ? fg_eff : new_values_q);
		res.signal       = cmd.tick ? (signal_q && !timed_out)
			: (cmd.frame_end ? (q_clamp > 9'sd0) : signal_q);
		res.glitch_count = (cmd.take && !cmd.ok) ? rejected_q + 16'd1 : rejected_q;
		res.pause_width  = cmd.sync ? cmd.sync_w : sync_width_q;
		res.ms_time      = cmd.tick ? ms_inc : ms_q;
	end

endmodule

### hw/rtl/ppm_frame_decoder_top.sv
// Top level of the PPM frame decoder: configuration registers, front end,
// command queue, back end and result queue. Depends on pfd_pkg and the pfd_* modules.
//
// Usage: each input word is either a captured 16-bit edge time (opcode 0)
// or a one-millisecond tick (opcode 1). Push a word while full is low; one
// result word comes back for every input word, in order, on the result
// ports while empty is low, and pop takes it.
// With both queues empty, an accepted word is registered in the command queue,
// applied by the back end into the result queue, and then shown on the result
// ports, where pop can take it. Throughput is one word per cycle while the result
// queue has room: the front end classifies a word in the cycle it is pushed, the
// back end applies one command per cycle, and two-entry queues sit between front
// and back and before the result ports.
// When the receiver stops popping, the result queue fills, the back end
// holds, then the command queue fills and full rises; nothing is dropped.
// Reset clears both queues, all decoder state and the channel values, and loads the
// default configuration. The registers sit on the APB port at byte addresses 4*i; the
// user must write them only while the decoder is idle; the block does not enforce it.
module ppm_frame_decoder_top #(
	parameter int MAX_CHANNELS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic                       opcode,
	input  logic [15:0]                edge_time,
	output logic                       empty,
	input  logic                       pop,
	output logic [3:0]                 channel,
	output logic [14:0]                value,
	output logic                       stored,
	output logic                       glitch,
	output logic                       sync,
	output logic                       frame_end,
	output logic                       new_values,
	output logic                       signal,
	output logic [15:0]                glitch_count,
	output logic [14:0]                pause_width,
	output logic [23:0]                ms_time
);
	import pfd_pkg::*;

	localparam int QUEUE_DEPTH = 2;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;
	logic     accept;
	cmd_t     cmd_in;
	cmd_t     cmd_out;
	logic     cmd_full;
	logic     cmd_empty;
	logic     back_fire;
	res_t     res_in;
	res_t     res_out;
	logic     res_full;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_pause_min    <= RST_SYNC_PAUSE_MIN;
			cfg_q.pulse_min         <= RST_PULSE_MIN;
			cfg_q.pulse_max         <= RST_PULSE_MAX;
			cfg_q.channel_count     <= RST_CHANNEL_COUNT;
			cfg_q.bad_frame_penalty <= RST_BAD_FRAME_PENALTY;
			cfg_q.bucket_limit      <= RST_BUCKET_LIMIT;
			cfg_q.signal_timeout_ms <= RST_SIGNAL_TIMEOUT_MS;
			cfg_q.halving_mode      <= RST_HALVING_MODE;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_SYNC_PAUSE_MIN:    cfg_q.sync_pause_min    <= pwdata[14:0];
				REG_PULSE_MIN:         cfg_q.pulse_min         <= pwdata[14:0];
				REG_PULSE_MAX:         cfg_q.pulse_max         <= pwdata[14:0];
				REG_CHANNEL_COUNT:     cfg_q.channel_count     <= pwdata[3:0];
				REG_BAD_FRAME_PENALTY: cfg_q.bad_frame_penalty <= pwdata[6:0];
				REG_BUCKET_LIMIT:      cfg_q.bucket_limit      <= pwdata[6:0];
				REG_SIGNAL_TIMEOUT_MS: cfg_q.signal_timeout_ms <= pwdata[15:0];
				REG_HALVING_MODE:      cfg_q.halving_mode      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_SYNC_PAUSE_MIN:    prdata = {17'd0, cfg_q.sync_pause_min};
			REG_PULSE_MIN:         prdata = {17'd0, cfg_q.pulse_min};
			REG_PULSE_MAX:         prdata = {17'd0, cfg_q.pulse_max};
			REG_CHANNEL_COUNT:     prdata = {28'd0, cfg_q.channel_count};
			REG_BAD_FRAME_PENALTY: prdata = {25'd0, cfg_q.bad_frame_penalty};
			REG_BUCKET_LIMIT:      prdata = {25'd0, cfg_q.bucket_limit};
			REG_SIGNAL_TIMEOUT_MS: prdata = {16'd0, cfg_q.signal_timeout_ms};
			REG_HALVING_MODE:      prdata = {31'd0, cfg_q.halving_mode};
			default:               prdata = '0;
		endcase
	end

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	pfd_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.edge_time(edge_time),
		.cfg      (cfg_q),
		.cmd      (cmd_in)
	);

	pfd_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(cmd_in),
		.rd_en  (back_fire),
		.rd_data(cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	assign back_fire = !cmd_empty && !res_full;

	pfd_back #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (back_fire),
		.cmd   (cmd_out),
		.cfg   (cfg_q),
		.res   (res_in)
	);

	pfd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (back_fire),
		.wr_data(res_in),
		.rd_en  (pop && !empty),
		.rd_data(res_out),
		.full   (res_full),
		.empty  (empty)
	);

	assign channel      = res_out.channel;
	assign value        = res_out.value;
	assign stored       = res_out.stored;
	assign glitch       = res_out.glitch;
	assign sync         = res_out.sync;
	assign frame_end    = res_out.frame_end;
	assign new_values   = res_out.new_values;
	assign signal       = res_out.signal;
	assign glitch_count = res_out.glitch_count;
	assign pause_width  = res_out.pause_width;
	assign ms_time      = res_out.ms_time;

endmodule

### hw/rtl/pfd_checker.sv
// Port-level checks of the PPM frame decoder, bound to the top level.
// Depends on ppm_frame_decoder_top and pfd_pkg.
module pfd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic [3:0]                 channel,
	input logic                       stored,
	input logic                       glitch,
	input logic                       sync,
	input logic                       frame_end,
	input logic [23:0]                ms_time
);
	import pfd_pkg::*;

	// A word cannot both store a value and count a glitch.
	a_store_xor_glitch: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(stored && glitch))
		else $error("stored and glitch set in one word");

	// A sync word touches no channel.
	a_sync_no_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sync) |-> (!stored && !glitch && !frame_end && channel == 4'd0))
		else $error("sync word carries channel fields");

	// A frame only ends on a word that took a pulse.
	a_frame_end_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (stored || glitch))
		else $error("frame end without a pulse");

	// A waiting word stays in place until it is popped.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(ms_time) && $stable(channel)))
		else $error("waiting result changed before pop");

endmodule

bind ppm_frame_decoder_top pfd_checker u_pfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.channel  (channel),
	.stored   (stored),
	.glitch   (glitch),
	.sync     (sync),
	.frame_end(frame_end),
	.ms_time  (ms_time)
);
